[design/u8d_pkg.sv]
// Shared types and codes for the UTF-8 stream decoder.
package u8d_pkg;

	localparam logic [1:0] KIND_CP   = 2'd0;
	localparam logic [1:0] KIND_CTRL = 2'd1;
	localparam logic [1:0] KIND_BAD  = 2'd2;

	typedef struct packed {
		logic        in_seq;
		logic [2:0]  need;
		logic [47:0] coll;
		logic [2:0]  cnt;
	} dec_state_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [30:0] code_point;
		logic [47:0] raw_bytes;
		logic [2:0]  raw_count;
	} result_t;

	localparam dec_state_t IDLE_STATE = '0;

endpackage

[design/u8d_in_if.sv]
// Input channel carrying one stream byte or an end-of-stream mark per word.
interface u8d_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_flag;

	modport source (output valid, output in_byte, output end_flag, input ready);
	modport sink (input valid, input in_byte, input end_flag, output ready);
endinterface

[design/u8d_out_if.sv]
// Output channel carrying one decoded, control or invalid result per word.
interface u8d_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [30:0] code_point;
	logic [47:0] raw_bytes;
	logic [2:0]  raw_count;

	modport source (output valid, output kind, output code_point, output raw_bytes,
		output raw_count, input ready);
	modport sink (input valid, input kind, input code_point, input raw_bytes,
		input raw_count, output ready);
endinterface

[design/utf8_stream_decoder.sv]
// Top level of the UTF-8 stream decoder: input register, sequence state and result register.
// A result passes through the input register and then the result register before it is offered.
// Throughput: one byte per cycle while the output side takes every word.
// Bytes that complete nothing, or end marks while idle, give no output word.
// Reset clears the input and result valid flags and returns the decoder to idle.
module utf8_stream_decoder (
	input logic       clk,
	input logic       arst_n,
	u8d_in_if.sink    in_ch,
	u8d_out_if.source out_ch
);
	import u8d_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;
	logic       advance;
	dec_state_t dec_state_q;
	dec_state_t dec_state_nxt;
	logic       emit;
	result_t    res;

	assign advance     = valid_s1 && (!out_ch.valid || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1 <= in_ch.in_byte;
			end_s1  <= in_ch.end_flag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_state_q <= IDLE_STATE;
		end else if (advance) begin
			dec_state_q <= dec_state_nxt;
		end
	end

	u8d_decode u_decode (
		.cur      (dec_state_q),
		.in_byte  (byte_s1),
		.end_flag (end_s1),
		.nxt      (dec_state_nxt),
		.emit     (emit),
		.res      (res)
	);

	u8d_out_reg u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance),
		.emit   (emit),
		.res    (res),
		.out_ch (out_ch)
	);

	a_seq_bounds : assert property (@(posedge clk) disable iff (!arst_n)
		dec_state_q.in_seq |-> (dec_state_q.cnt != 3'd0 && dec_state_q.need != 3'd0 &&
		({1'b0, dec_state_q.cnt} + {1'b0, dec_state_q.need}) <= 4'd6))
		else $error("Open sequence has an impossible byte count.");

	a_idle_clean : assert property (@(posedge clk) disable iff (!arst_n)
		!dec_state_q.in_seq |-> (dec_state_q.cnt == 3'd0 && dec_state_q.need == 3'd0 &&
		dec_state_q.coll == 48'd0))
		else $error("Idle decoder holds leftover sequence bytes.");

	a_end_idles : assert property (@(posedge clk) disable iff (!arst_n)
		advance && end_s1 |=> !dec_state_q.in_seq)
		else $error("End of stream did not return the decoder to idle.");

	a_cp_no_raw : assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.kind == KIND_CP |->
		(out_ch.raw_count == 3'd0 && out_ch.raw_bytes == 48'd0))
		else $error("Code point word carries raw bytes.");

	a_raw_nonempty : assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && (out_ch.kind == KIND_CTRL || out_ch.kind == KIND_BAD) |->
		(out_ch.raw_count != 3'd0 && out_ch.code_point == 31'd0))
		else $error("Raw word has no bytes or a code point.");
endmodule

[design/u8d_decode.sv]
// Combinational decode of one byte against the current sequence state.
module u8d_decode (
	input  u8d_pkg::dec_state_t cur,
	input  logic [7:0]          in_byte,
	input  logic                end_flag,
	output u8d_pkg::dec_state_t nxt,
	output logic                emit,
	output u8d_pkg::result_t    res
);
	import u8d_pkg::*;

	logic [47:0] merged;
	logic [2:0]  cnt_n;
	logic [30:0] cp;
	logic [30:0] lo;
	logic        bad;

	assign merged = cur.coll | ({40'd0, in_byte} << {cur.cnt, 3'b000});
	assign cnt_n  = cur.cnt + 3'd1;

	always_comb begin
		unique case (cnt_n)
			3'd2: begin
				cp = {20'd0, merged[4:0], merged[13:8]};
				lo = 31'h80;
			end
			3'd3: begin
				cp = {15'd0, merged[3:0], merged[13:8], merged[21:16]};
				lo = 31'h800;
			end
			3'd4: begin
				cp = {10'd0, merged[2:0], merged[13:8], merged[21:16], merged[29:24]};
				lo = 31'h10000;
			end
			3'd5: begin
				cp = {5'd0, merged[1:0], merged[13:8], merged[21:16], merged[29:24],
					merged[37:32]};
				lo = 31'h200000;
			end
			default: begin
				cp = {merged[0], merged[13:8], merged[21:16], merged[29:24],
					merged[37:32], merged[45:40]};
				lo = 31'h4000000;
			end
		endcase
	end

	assign bad = (cp < lo) || (cp >= 31'hD800 && cp <= 31'hDFFF);

	always_comb begin
		nxt  = cur;
		emit = 1'b0;
		res  = '0;
		if (end_flag) begin
			if (cur.in_seq) begin
				emit          = 1'b1;
				res.kind      = KIND_BAD;
				res.raw_bytes = cur.coll;
				res.raw_count = cur.cnt;
				nxt           = IDLE_STATE;
			end
		end else if (!cur.in_seq) begin
			priority if (in_byte >= 8'h20 && in_byte <= 8'h7E) begin
				emit           = 1'b1;
				res.kind       = KIND_CP;
				res.code_point = {23'd0, in_byte};
			end else if (in_byte < 8'h20 || in_byte == 8'h7F) begin
				emit          = 1'b1;
				res.kind      = KIND_CTRL;
				res.raw_bytes = {40'd0, in_byte};
				res.raw_count = 3'd1;
			end else if (in_byte < 8'hC0 || in_byte >= 8'hFE) begin
				emit          = 1'b1;
				res.kind      = KIND_BAD;
				res.raw_bytes = {40'd0, in_byte};
				res.raw_count = 3'd1;
			end else begin
				nxt.in_seq = 1'b1;
				nxt.coll   = {40'd0, in_byte};
				nxt.cnt    = 3'd1;
				priority if (in_byte < 8'hE0) begin
					nxt.need = 3'd1;
				end else if (in_byte < 8'hF0) begin
					nxt.need = 3'd2;
				end else if (in_byte < 8'hF8) begin
					nxt.need = 3'd3;
				end else if (in_byte < 8'hFC) begin
					nxt.need = 3'd4;
				end else begin
					nxt.need = 3'd5;
				end
			end
		end else if (in_byte[7:6] != 2'b10) begin
			emit          = 1'b1;
			res.kind      = KIND_BAD;
			res.raw_bytes = merged;
			res.raw_count = cnt_n;
			nxt           = IDLE_STATE;
		end else if (cur.need > 3'd1) begin
			nxt.need = cur.need - 3'd1;
			nxt.coll = merged;
			nxt.cnt  = cnt_n;
		end else begin
			nxt = IDLE_STATE;
			if (bad) begin
				emit          = 1'b1;
				res.kind      = KIND_BAD;
				res.raw_bytes = merged;
				res.raw_count = cnt_n;
			end else if (cp != 31'hFEFF) begin
				emit           = 1'b1;
				res.kind       = KIND_CP;
				res.code_point = cp;
			end
		end
	end
endmodule

[design/u8d_out_reg.sv]
// Result register that holds one word for the output channel.
module u8d_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic             emit,
	input  u8d_pkg::result_t res,
	u8d_out_if.source        out_ch
);
	import u8d_pkg::*;

	logic    valid_s2;
	result_t res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= emit;
		end else if (out_ch.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && emit) begin
			res_s2 <= res;
		end
	end

	assign out_ch.valid      = valid_s2;
	assign out_ch.kind       = res_s2.kind;
	assign out_ch.code_point = res_s2.code_point;
	assign out_ch.raw_bytes  = res_s2.raw_bytes;
	assign out_ch.raw_count  = res_s2.raw_count;
endmodule
